FILE: rtl/fpss_pkg.sv
// ----------------------------------------------------------------------------
// Five-point stencil sum: shared types and constants
// Widths, configuration register codes and the structs passed between the
// configuration block, the line buffer and the top level.
// ----------------------------------------------------------------------------
package fpss_pkg;

   // Grid and value sizes.
   localparam int MAX_INTERIOR = 1024;
   localparam int VALUE_BITS   = 32;
   localparam int POS_BITS     = 11;
   localparam int STORE_DEPTH  = MAX_INTERIOR + 2;
   localparam int ADDR_BITS    = $clog2(STORE_DEPTH);
   localparam int CSR_BITS     = 11;
   localparam int CSR_IDX_BITS = 3;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_INTERIOR_WIDTH = 3'd0,
      CSR_TILE_HEIGHT    = 3'd1,
      CSR_TILE_WIDTH     = 3'd2,
      CSR_TILES_DOWN     = 3'd3,
      CSR_TILES_ACROSS   = 3'd4
   } csr_index_type;

   // Reset values of the configuration registers.
   localparam logic [CSR_BITS-1:0] RST_INTERIOR_WIDTH = 11'd1024;
   localparam logic [CSR_BITS-1:0] RST_TILE_HEIGHT    = 11'd1024;
   localparam logic [CSR_BITS-1:0] RST_TILE_WIDTH     = 11'd1024;
   localparam logic [CSR_BITS-1:0] RST_TILES_DOWN     = 11'd1;
   localparam logic [CSR_BITS-1:0] RST_TILES_ACROSS   = 11'd1;

   typedef logic signed [VALUE_BITS-1:0] value_type;
   typedef logic [POS_BITS-1:0]          pos_type;

   // Derived geometry from the configuration registers.
   typedef struct packed {
      pos_type last;   // last padded index of a row or column
      pos_type rmax;   // last covered interior row
      pos_type cmax;   // last covered interior column
   } cfg_type;

   // One line buffer entry: padded rows r-2 and r-1 at one column.
   typedef struct packed {
      value_type older;
      value_type newer;
   } entry_type;

   // Neighborhood of the point above the arriving value.
   typedef struct packed {
      value_type left;
      value_type top;
      value_type centre;
      value_type right;
   } window_type;

   // Padded position of the arriving value.
   typedef struct packed {
      pos_type row;
      pos_type col;
   } position_type;

endpackage

FILE: rtl/fpss_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module fpss_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1026
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/fpss_csr.sv
// ----------------------------------------------------------------------------
// Five-point stencil sum: configuration registers
// Holds the five geometry registers and derives the row length and the
// clipped extent of the covered region.
// ----------------------------------------------------------------------------
module fpss_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [fpss_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [fpss_pkg::CSR_BITS-1:0]     csr_wdata,
   output fpss_pkg::cfg_type                 cfg
);

   logic [fpss_pkg::CSR_BITS-1:0] width_ff;
   logic [fpss_pkg::CSR_BITS-1:0] theight_ff;
   logic [fpss_pkg::CSR_BITS-1:0] twidth_ff;
   logic [fpss_pkg::CSR_BITS-1:0] tdown_ff;
   logic [fpss_pkg::CSR_BITS-1:0] tacross_ff;

   logic [fpss_pkg::POS_BITS-1:0]     side;
   logic [2*fpss_pkg::CSR_BITS-1:0]   rows_span;
   logic [2*fpss_pkg::CSR_BITS-1:0]   cols_span;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= fpss_pkg::RST_INTERIOR_WIDTH;
         theight_ff <= fpss_pkg::RST_TILE_HEIGHT;
         twidth_ff  <= fpss_pkg::RST_TILE_WIDTH;
         tdown_ff   <= fpss_pkg::RST_TILES_DOWN;
         tacross_ff <= fpss_pkg::RST_TILES_ACROSS;
      end else if (csr_we) begin
         unique case (csr_index)
            fpss_pkg::CSR_INTERIOR_WIDTH: width_ff   <= csr_wdata;
            fpss_pkg::CSR_TILE_HEIGHT:    theight_ff <= csr_wdata;
            fpss_pkg::CSR_TILE_WIDTH:     twidth_ff  <= csr_wdata;
            fpss_pkg::CSR_TILES_DOWN:     tdown_ff   <= csr_wdata;
            fpss_pkg::CSR_TILES_ACROSS:   tacross_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Interior side clamped to the supported range.
   always_comb begin
      if (width_ff == '0) begin
         side = fpss_pkg::POS_BITS'(1);
      end else if (width_ff > fpss_pkg::POS_BITS'(fpss_pkg::MAX_INTERIOR)) begin
         side = fpss_pkg::POS_BITS'(fpss_pkg::MAX_INTERIOR);
      end else begin
         side = width_ff;
      end
   end

   // Covered region, clipped to the interior.
   assign rows_span = theight_ff * tdown_ff;
   assign cols_span = twidth_ff * tacross_ff;

   always_comb begin
      cfg.last = side + fpss_pkg::POS_BITS'(1);
      cfg.rmax = (rows_span < {{fpss_pkg::CSR_BITS{1'b0}}, side}) ?
                 rows_span[fpss_pkg::POS_BITS-1:0] : side;
      cfg.cmax = (cols_span < {{fpss_pkg::CSR_BITS{1'b0}}, side}) ?
                 cols_span[fpss_pkg::POS_BITS-1:0] : side;
   end

endmodule

FILE: rtl/fpss_linebuf.sv
// ----------------------------------------------------------------------------
// Five-point stencil sum: line buffer and window
// Tracks the padded position, keeps the two previous rows in one RAM and
// presents the neighborhood of the point above the arriving value.
// ----------------------------------------------------------------------------
module fpss_linebuf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  fpss_pkg::value_type    grid_value,
   input  fpss_pkg::cfg_type      cfg,
   output fpss_pkg::window_type   window,
   output fpss_pkg::position_type position
);

   localparam int EntryBits = 2 * fpss_pkg::VALUE_BITS;

   logic [fpss_pkg::POS_BITS-1:0] row_ff;
   logic [fpss_pkg::POS_BITS-1:0] col_ff;
   fpss_pkg::value_type           left_ff;
   fpss_pkg::entry_type           cur_ff;

   logic [fpss_pkg::POS_BITS-1:0]  row;
   logic [fpss_pkg::POS_BITS-1:0]  col;
   logic [fpss_pkg::POS_BITS:0]    ahead;
   logic [fpss_pkg::POS_BITS:0]    ahead_wrapped;
   logic [fpss_pkg::ADDR_BITS-1:0] rd_addr;
   fpss_pkg::entry_type            wr_entry;
   fpss_pkg::entry_type            rd_entry;
   logic [EntryBits-1:0]           rd_bits;

   // Position of the arriving value; a counter beyond the row wraps to zero.
   assign row = (row_ff > cfg.last) ? '0 : row_ff;
   assign col = (col_ff > cfg.last) ? '0 : col_ff;

   // Prefetch two columns ahead, wrapping into the next row.
   assign ahead = {1'b0, col} + (fpss_pkg::POS_BITS+1)'(2);
   assign ahead_wrapped = (ahead > {1'b0, cfg.last}) ?
                          ahead - ({1'b0, cfg.last} + (fpss_pkg::POS_BITS+1)'(1)) : ahead;
   assign rd_addr = ahead_wrapped[fpss_pkg::ADDR_BITS-1:0];

   // The current column's entry shifts down one row.
   assign wr_entry.older = cur_ff.newer;
   assign wr_entry.newer = grid_value;
   assign rd_entry       = fpss_pkg::entry_type'(rd_bits);

   fpss_ram #(
      .WIDTH (EntryBits),
      .DEPTH (fpss_pkg::STORE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col[fpss_pkg::ADDR_BITS-1:0]),
      .wr_data (EntryBits'(wr_entry)),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_bits)
   );

   // Position counters and the left neighbor.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         left_ff <= '0;
      end else if (accept) begin
         if (col >= cfg.last) begin
            col_ff  <= '0;
            row_ff  <= (row >= cfg.last) ? '0 : row + fpss_pkg::POS_BITS'(1);
            left_ff <= '0;
         end else begin
            col_ff  <= col + fpss_pkg::POS_BITS'(1);
            left_ff <= cur_ff.newer;
         end
      end
   end

   // The prefetched entry becomes the current column's entry.
   always_ff @(posedge clock) begin
      if (accept) begin
         cur_ff <= rd_entry;
      end
   end

   assign window.left   = left_ff;
   assign window.top    = cur_ff.older;
   assign window.centre = cur_ff.newer;
   assign window.right  = rd_entry.newer;
   assign position.row  = row;
   assign position.col  = col;

endmodule

FILE: rtl/five_point_stencil_sum.sv
// ----------------------------------------------------------------------------
// Five-point stencil sum: top level
// A result is registered on rsp_ in the cycle after the request that completes it is accepted.
// Throughput: one request per cycle; the prefetching line buffer RAM and the
// combinational five-input adder set that rate, and rsp_ backpressure stalls it.
// Reset returns the configuration to its defaults and clears the position
// counters and the result valid flag; the line buffer RAM is not cleared.
// ----------------------------------------------------------------------------
module five_point_stencil_sum (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] grid_value
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [31:0] stencil_sum, [42:32] out_row,
                                    // [53:43] out_col, [55:54] zero
   output logic        rsp_tlast,   // frame_last
   // Configuration port
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [10:0] csr_wdata
);

   fpss_pkg::cfg_type      cfg;
   fpss_pkg::window_type   window;
   fpss_pkg::position_type position;
   fpss_pkg::value_type    grid_value;
   fpss_pkg::value_type    sum;
   fpss_pkg::pos_type      row_above;
   logic                   accept;
   logic                   hit;
   logic                   frame_end;

   logic                   rsp_valid_ff;
   fpss_pkg::value_type    sum_ff;
   fpss_pkg::pos_type      out_row_ff;
   fpss_pkg::pos_type      out_col_ff;
   logic                   frame_last_ff;

   assign grid_value = fpss_pkg::value_type'(req_tdata);
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   fpss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fpss_linebuf u_linebuf (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .grid_value (grid_value),
      .cfg        (cfg),
      .window     (window),
      .position   (position)
   );

   // Sum and coverage test for the point above the arriving value.
   assign sum = window.left + window.top + window.centre + window.right + grid_value;
   assign row_above = position.row - fpss_pkg::POS_BITS'(1);
   assign hit = (position.row >= fpss_pkg::POS_BITS'(2)) && (row_above <= cfg.rmax) &&
                (position.col != '0) && (position.col <= cfg.cmax);
   assign frame_end = (row_above == cfg.rmax) && (position.col == cfg.cmax);

   // Output register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= hit;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      if (accept && hit) begin
         sum_ff        <= sum;
         out_row_ff    <= row_above;
         out_col_ff    <= position.col;
         frame_last_ff <= frame_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, out_col_ff, out_row_ff, sum_ff};
   assign rsp_tlast  = frame_last_ff;

endmodule

FILE: rtl/fpss_checker.sv
// ----------------------------------------------------------------------------
// Five-point stencil sum: port checker
// Watches the top-level ports for result-channel and flow-control slips.
// ----------------------------------------------------------------------------
module fpss_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic        rsp_tlast
);

   // A stalled result keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
   else $error("stalled result changed");

   // With the output register empty the block is always ready for a request.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
   else $error("request refused while output register empty");

   // A new result only follows an accepted request.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !$past(rsp_tvalid) |-> $past(req_tvalid && req_tready))
   else $error("result appeared without a request");

   // Reported positions lie in the interior, clear of the padding.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[42:32] != 11'd0 && rsp_tdata[53:43] != 11'd0 &&
                     rsp_tdata[42:32] <= 11'd1024 && rsp_tdata[53:43] <= 11'd1024)
   else $error("result position outside the interior");

endmodule

bind five_point_stencil_sum fpss_checker u_fpss_checker (.*);

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Five-point stencil sum: self-checking regression
// Streams padded grids through the block under many geometries, predicts
// every stencil result in the testbench, and compares results field by field
// under random request gaps, response stalls and long response hold-offs.
// ----------------------------------------------------------------------------
module tb;

   localparam int unsigned         RESET_CYCLES  = 9;
   localparam int unsigned         SETTLE_CYCLES = 4;
   localparam int unsigned         LONG_HOLD     = 300;
   localparam int unsigned         RANDOM_ITEMS  = 150;
   localparam int unsigned         RUN_LIMIT     = 1000000;
   localparam fpss_pkg::value_type VALUE_MAX     = 32'sh7fffffff;
   localparam fpss_pkg::value_type VALUE_MIN     = 32'sh80000000;

   // One expected stencil result.
   typedef struct {
      fpss_pkg::value_type sum;
      fpss_pkg::pos_type   row;
      fpss_pkg::pos_type   col;
      logic                frame_end;
   } stencil_result_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata   = '0;   // [31:0] grid_value
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [55:0] rsp_tdata;          // [31:0] stencil_sum, [42:32] out_row,
                                    // [53:43] out_col, [55:54] zero
   logic        rsp_tlast;          // frame_last
   logic        csr_we      = 1'b0;
   logic [2:0]  csr_index   = '0;
   logic [10:0] csr_wdata   = '0;

   // Copy of the configuration registers.
   fpss_pkg::pos_type cfg_width        = fpss_pkg::RST_INTERIOR_WIDTH;
   fpss_pkg::pos_type cfg_tile_height  = fpss_pkg::RST_TILE_HEIGHT;
   fpss_pkg::pos_type cfg_tile_width   = fpss_pkg::RST_TILE_WIDTH;
   fpss_pkg::pos_type cfg_tiles_down   = fpss_pkg::RST_TILES_DOWN;
   fpss_pkg::pos_type cfg_tiles_across = fpss_pkg::RST_TILES_ACROSS;

   // Line buffers, left neighbor and raster position of the next value.
   fpss_pkg::value_type two_rows_up [fpss_pkg::STORE_DEPTH];
   fpss_pkg::value_type one_row_up  [fpss_pkg::STORE_DEPTH];
   fpss_pkg::value_type left_value = '0;
   int unsigned         next_row   = 0;
   int unsigned         next_col   = 0;

   stencil_result_type pending_sums [$];

   int unsigned error_count   = 0;
   int unsigned items_sent    = 0;
   int unsigned cycles_run    = 0;
   int unsigned max_gap       = 0;
   int unsigned burst_left    = 0;
   logic        offering      = 1'b0;
   int unsigned holds_wanted  = 0;
   int unsigned holds_given   = 0;
   int unsigned hold_left     = 0;
   logic [6:0]  stall_pattern = 7'h7f;
   int unsigned stall_phase   = 0;

   five_point_stencil_sum u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Interior side after clamping to the supported range.
   function automatic int unsigned clamped_side();
      int unsigned w;
      w = cfg_width;
      if (w < 1) w = 1;
      if (w > fpss_pkg::MAX_INTERIOR) w = fpss_pkg::MAX_INTERIOR;
      return w;
   endfunction

   // Steps the raster position by one value and queues the finished point.
   task automatic advance_stencil(input fpss_pkg::value_type v);
      int unsigned         w, edge_idx, rmax, cmax, r, c;
      fpss_pkg::value_type top, centre, right;
      stencil_result_type  res;
      w        = clamped_side();
      edge_idx = w + 1;
      rmax     = cfg_tile_height * cfg_tiles_down;
      cmax     = cfg_tile_width * cfg_tiles_across;
      if (rmax > w) rmax = w;
      if (cmax > w) cmax = w;
      // A position left beyond a shrunken grid restarts the frame.
      if (next_row > edge_idx) next_row = 0;
      if (next_col > edge_idx) next_col = 0;
      r = next_row;
      c = next_col;
      top    = two_rows_up[c];
      centre = one_row_up[c];
      right  = (c + 1 < fpss_pkg::STORE_DEPTH) ? one_row_up[c + 1] : '0;
      if (r >= 2 && r - 1 <= rmax && c >= 1 && c <= cmax) begin
         res.sum       = left_value + top + centre + right + v;
         res.row       = fpss_pkg::pos_type'(r - 1);
         res.col       = fpss_pkg::pos_type'(c);
         res.frame_end = (r - 1 == rmax && c == cmax);
         pending_sums.push_back(res);
      end
      two_rows_up[c] = centre;
      one_row_up[c]  = v;
      left_value     = centre;
      if (c >= edge_idx) begin
         next_col   = 0;
         next_row   = (r >= edge_idx) ? 0 : r + 1;
         left_value = '0;
      end else begin
         next_col = c + 1;
      end
   endtask

   // Writes one configuration register; the block must be idle.
   task automatic write_csr(input fpss_pkg::csr_index_type idx, input fpss_pkg::pos_type v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         fpss_pkg::CSR_INTERIOR_WIDTH: cfg_width        = v;
         fpss_pkg::CSR_TILE_HEIGHT:    cfg_tile_height  = v;
         fpss_pkg::CSR_TILE_WIDTH:     cfg_tile_width   = v;
         fpss_pkg::CSR_TILES_DOWN:     cfg_tiles_down   = v;
         fpss_pkg::CSR_TILES_ACROSS:   cfg_tiles_across = v;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Offers one grid value, waits for the handshake, then maybe pauses.
   task automatic send_value(input fpss_pkg::value_type v);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      offering = 1'b1;
      do @(posedge clock); while (!req_tready);
      advance_stencil(v);
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 20);
         gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   function automatic fpss_pkg::value_type pick_value();
      case ($urandom_range(0, 9))
         0:       return VALUE_MAX;
         1:       return VALUE_MIN;
         2:       return -1;
         3:       return 0;
         default: return $urandom();
      endcase
   endfunction

   task automatic send_values(input int unsigned n);
      for (int unsigned k = 0; k < n; k++) send_value(pick_value());
   endtask

   task automatic send_rows(input int unsigned rows);
      send_values(rows * (clamped_side() + 2));
   endtask

   task automatic send_frame();
      send_rows(clamped_side() + 2);
   endtask

   // Stops offering requests and waits until every result is back.
   task automatic drain_results();
      if (offering) begin
         req_tvalid <= 1'b0;
         offering = 1'b0;
      end
      while (pending_sums.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_geometry(input fpss_pkg::pos_type w, input fpss_pkg::pos_type th,
                                 input fpss_pkg::pos_type tw, input fpss_pkg::pos_type td,
                                 input fpss_pkg::pos_type ta);
      write_csr(fpss_pkg::CSR_INTERIOR_WIDTH, w);
      write_csr(fpss_pkg::CSR_TILE_HEIGHT, th);
      write_csr(fpss_pkg::CSR_TILE_WIDTH, tw);
      write_csr(fpss_pkg::CSR_TILES_DOWN, td);
      write_csr(fpss_pkg::CSR_TILES_ACROSS, ta);
   endtask

   // Reset geometry: a few values at the full 1024 side leave the column
   // counter inside a five-wide row, so the frame carries on from there and
   // the reset tile registers cover the whole interior.
   task automatic test_reset_geometry();
      max_gap = 2;
      send_values(4);
      drain_results();
      write_csr(fpss_pkg::CSR_INTERIOR_WIDTH, 11'd5);
      send_values(45);
      drain_results();
      write_csr(fpss_pkg::CSR_INTERIOR_WIDTH, 11'd1);
   endtask

   // Largest and smallest values, so that the five-way sum wraps.
   task automatic test_extreme_values();
      for (int unsigned k = 0; k < 9; k++) send_value(VALUE_MAX);
      drain_results();
      write_csr(fpss_pkg::CSR_INTERIOR_WIDTH, 11'd2);
      for (int unsigned k = 0; k < 16; k++) begin
         case (k % 4)
            0, 1:    send_value(VALUE_MIN);
            2:       send_value(-1);
            default: send_value(VALUE_MAX);
         endcase
      end
      drain_results();
   endtask

   // Side zero acts as one, side above the maximum acts as the maximum, so
   // a few values there keep the column counter running as in a long row.
   task automatic test_width_clamping();
      write_csr(fpss_pkg::CSR_INTERIOR_WIDTH, 11'd0);
      send_frame();
      drain_results();
      write_geometry(11'd2047, 11'd1, 11'd2047, 11'd1, 11'd2047);
      send_values(4);
      drain_results();
      write_csr(fpss_pkg::CSR_INTERIOR_WIDTH, 11'd5);
      send_values(45);
      drain_results();
      write_csr(fpss_pkg::CSR_INTERIOR_WIDTH, 11'd1);
      send_frame();
      drain_results();
   endtask

   // Empty regions, region products past 11 bits, and clipped sub-regions.
   task automatic test_tile_region();
      write_geometry(11'd4, 11'd0, 11'd4, 11'd1, 11'd1);
      send_frame();
      drain_results();
      write_geometry(11'd4, 11'd2, 11'd4, 11'd2, 11'd0);
      send_frame();
      drain_results();
      write_geometry(11'd5, 11'd1024, 11'd1024, 11'd2, 11'd2);
      send_frame();
      drain_results();
      write_geometry(11'd6, 11'd2, 11'd1, 11'd1, 11'd3);
      send_frame();
      drain_results();
   endtask

   // Tile registers changed halfway through a frame take effect at once.
   task automatic test_mid_frame_update();
      write_geometry(11'd6, 11'd3, 11'd6, 11'd2, 11'd1);
      send_rows(4);
      drain_results();
      write_csr(fpss_pkg::CSR_TILE_WIDTH, 11'd2);
      write_csr(fpss_pkg::CSR_TILES_ACROSS, 11'd2);
      send_rows(4);
      drain_results();
   endtask

   // The receiver holds off for a long stretch while requests keep coming.
   task automatic test_output_backpressure();
      write_geometry(11'd8, 11'd8, 11'd8, 11'd1, 11'd1);
      max_gap = 0;
      holds_wanted++;
      send_frame();
      drain_results();
   endtask

   function automatic fpss_pkg::pos_type pick_tile_size(input fpss_pkg::pos_type w);
      case ($urandom_range(0, 9))
         0:       return 11'd0;
         1:       return 11'd2047;
         2:       return fpss_pkg::pos_type'($urandom_range(w, 40));
         default: return fpss_pkg::pos_type'($urandom_range(1, w));
      endcase
   endfunction

   function automatic fpss_pkg::pos_type pick_tile_count();
      case ($urandom_range(0, 9))
         0:       return 11'd0;
         1:       return 11'd2047;
         default: return fpss_pkg::pos_type'($urandom_range(1, 3));
      endcase
   endfunction

   // Whole frames with random geometry, content and idling.
   task automatic test_random_frames();
      int unsigned       start_items;
      fpss_pkg::pos_type w;
      start_items = items_sent;
      while (items_sent - start_items < RANDOM_ITEMS) begin
         w = ($urandom_range(0, 9) == 0) ? fpss_pkg::pos_type'($urandom_range(13, 20))
                                         : fpss_pkg::pos_type'($urandom_range(1, 12));
         write_geometry(w, pick_tile_size(w), pick_tile_size(w),
                        pick_tile_count(), pick_tile_count());
         max_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if ($urandom_range(0, 11) == 0) holds_wanted++;
         send_frame();
         drain_results();
      end
   endtask

   // Result ready: a rotating stall pattern, or a long hold when requested.
   always @(posedge clock) begin
      if (holds_wanted != holds_given) begin
         hold_left = LONG_HOLD;
         holds_given++;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= stall_pattern[stall_phase];
         if (stall_phase == 6) begin
            stall_phase = 0;
            if ($urandom_range(0, 7) == 0)
               stall_pattern = ($urandom_range(0, 2) == 0) ? 7'h7f
                                                           : 7'($urandom_range(1, 127));
         end else begin
            stall_phase++;
         end
      end
   end

   task automatic flag_error(input string msg);
      if (error_count < 10) $display("ERROR: %s", msg);
      error_count++;
   endtask

   // Compares each accepted result with the oldest expected one.
   always @(posedge clock) begin : result_check
      stencil_result_type  want;
      fpss_pkg::value_type got_sum;
      fpss_pkg::pos_type   got_row, got_col;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_sum = rsp_tdata[31:0];
         got_row = rsp_tdata[42:32];
         got_col = rsp_tdata[53:43];
         if (pending_sums.size() == 0) begin
            flag_error($sformatf("unexpected result: sum %0d row %0d col %0d last %0b",
                                 got_sum, got_row, got_col, rsp_tlast));
         end else begin
            want = pending_sums.pop_front();
            if (got_sum !== want.sum || got_row !== want.row || got_col !== want.col ||
                rsp_tlast !== want.frame_end || rsp_tdata[55:54] !== 2'b00)
               flag_error($sformatf(
                  "expected sum %0d row %0d col %0d last %0b, got %0d %0d %0d %0b pad %b",
                  want.sum, want.row, want.col, want.frame_end,
                  got_sum, got_row, got_col, rsp_tlast, rsp_tdata[55:54]));
         end
      end
   end

   // Watchdog on total run length.
   initial begin : watchdog
      while (cycles_run < RUN_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("five_point_stencil_sum regression: fail");
      $finish;
   end

   initial begin : regression
      for (int k = 0; k < fpss_pkg::STORE_DEPTH; k++) begin
         two_rows_up[k] = '0;
         one_row_up[k]  = '0;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_geometry();
      test_extreme_values();
      test_width_clamping();
      test_tile_region();
      test_mid_frame_update();
      test_output_backpressure();
      test_random_frames();
      if (error_count == 0 && pending_sums.size() == 0)
         $display("five_point_stencil_sum regression: pass");
      else
         $display("five_point_stencil_sum regression: fail");
      $finish;
   end

endmodule
